FILE: sv/rmth_pkg.sv
// Shared types and constants of the running median block.
package rmth_pkg;

    localparam int HALF_DEPTH_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    // Half select: lower half is kept ascending, upper half descending,
    // so the extreme of each half sits at its last valid entry.
    localparam logic HALF_LOWER = 1'b0;
    localparam logic HALF_UPPER = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_INS_RD,
        S_INS_CMP,
        S_PUBLISH
    } state_t;

    typedef struct packed {
        logic load;
        logic decide;
        logic ins_rd;
        logic ins_cmp;
        logic publish;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic fin;
        logic need2;
    } status_t;

endpackage

FILE: sv/rmth_ctrl.sv
// Sequencer of the running median block: request handshake and insert steps.
module rmth_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output rmth_pkg::cmd_t   cmd,
    input  rmth_pkg::status_t st
);

    rmth_pkg::state_t state_reg, state_next;
    logic m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rmth_pkg::S_IDLE: begin
                if (s_tvalid && s_tready) state_next = rmth_pkg::S_DECIDE;
            end
            rmth_pkg::S_DECIDE: begin
                state_next = st.full ? rmth_pkg::S_PUBLISH : rmth_pkg::S_INS_RD;
            end
            rmth_pkg::S_INS_RD: begin
                if (st.fin) begin
                    state_next = st.need2 ? rmth_pkg::S_INS_RD : rmth_pkg::S_PUBLISH;
                end else begin
                    state_next = rmth_pkg::S_INS_CMP;
                end
            end
            rmth_pkg::S_INS_CMP: begin
                if (st.fin) begin
                    state_next = st.need2 ? rmth_pkg::S_INS_RD : rmth_pkg::S_PUBLISH;
                end else begin
                    state_next = rmth_pkg::S_INS_RD;
                end
            end
            rmth_pkg::S_PUBLISH: state_next = rmth_pkg::S_IDLE;
            default:             state_next = rmth_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_tready    = (state_reg == rmth_pkg::S_IDLE) && (!m_valid_reg || m_tready);
        cmd.load    = s_tvalid && s_tready;
        cmd.decide  = (state_reg == rmth_pkg::S_DECIDE);
        cmd.ins_rd  = (state_reg == rmth_pkg::S_INS_RD);
        cmd.ins_cmp = (state_reg == rmth_pkg::S_INS_CMP);
        cmd.publish = (state_reg == rmth_pkg::S_PUBLISH);
        m_valid_next = cmd.publish ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rmth_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

    // output slot is free whenever an item is in flight
    a_busy_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != rmth_pkg::S_IDLE) |-> !m_valid_reg)
        else $error("result pending while item in flight");

    // one result per accepted request
    a_publish_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish |=> (m_valid_reg && state_reg == rmth_pkg::S_IDLE))
        else $error("publish did not raise result");

endmodule

FILE: sv/rmth_dp.sv
// Datapath of the running median block: two sorted half memories and insert engine.
module rmth_dp #(
    parameter int HALF_DEPTH  = rmth_pkg::HALF_DEPTH_DEF,
    parameter int SAMPLE_BITS = rmth_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rmth_pkg::cmd_t                cmd,
    output rmth_pkg::status_t             st,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          restart,
    output logic signed [SAMPLE_BITS-1:0] median,
    output logic                          dropped
);

    localparam int CW = $clog2(HALF_DEPTH + 1);
    localparam int AW = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;

    logic signed [SAMPLE_BITS-1:0] lo_mem [HALF_DEPTH];
    logic signed [SAMPLE_BITS-1:0] up_mem [HALF_DEPTH];

    logic signed [SAMPLE_BITS-1:0] samp_reg, lo_top_reg, up_top_reg, op_val_reg, val2_reg;
    logic signed [SAMPLE_BITS-1:0] med_reg, lo_rd_reg, up_rd_reg;
    logic                          rst_reg, drop_reg, op_half_reg, half2_reg;
    logic                          first_reg, need2_reg;
    logic [CW-1:0]                 lc_reg, uc_reg;
    logic [AW-1:0]                 idx_reg;

    logic [CW-1:0]                 lce, uce, lcm1, ucm1;
    logic                          full, shift, idx_zero, fin, wr_en;
    logic signed [SAMPLE_BITS-1:0] rd_data, wr_data;
    logic [AW-1:0]                 rd_addr;

    always_comb begin
        lce      = rst_reg ? '0 : lc_reg;
        uce      = rst_reg ? '0 : uc_reg;
        lcm1     = lce - 1'b1;
        ucm1     = uce - 1'b1;
        full     = (lce == CW'(HALF_DEPTH)) && (uce == CW'(HALF_DEPTH));
        rd_data  = op_half_reg ? up_rd_reg : lo_rd_reg;
        shift    = op_half_reg ? (rd_data < op_val_reg) : (rd_data > op_val_reg);
        idx_zero = (idx_reg == '0);
        fin      = (cmd.ins_rd && idx_zero) || (cmd.ins_cmp && !shift);
        wr_en    = (cmd.ins_rd && idx_zero) || cmd.ins_cmp;
        wr_data  = (cmd.ins_cmp && shift) ? rd_data : op_val_reg;
        rd_addr  = idx_reg - 1'b1;
        st.full  = full;
        st.fin   = fin;
        st.need2 = need2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lc_reg    <= '0;
            uc_reg    <= '0;
            need2_reg <= 1'b0;
            first_reg <= 1'b0;
            rst_reg   <= 1'b0;
        end else begin
            if (cmd.load) begin
                samp_reg <= sample;
                rst_reg  <= restart;
            end
            if (cmd.decide) begin
                drop_reg <= full;
                if (full) begin
                    need2_reg <= 1'b0;
                end else begin
                    first_reg  <= 1'b1;
                    op_val_reg <= samp_reg;
                    if (lce > uce && samp_reg < lo_top_reg) begin
                        // sample replaces lower max, old max moves up
                        lc_reg      <= lcm1;
                        uc_reg      <= uce;
                        op_half_reg <= rmth_pkg::HALF_LOWER;
                        idx_reg     <= lcm1[AW-1:0];
                        need2_reg   <= 1'b1;
                        val2_reg    <= lo_top_reg;
                        half2_reg   <= rmth_pkg::HALF_UPPER;
                    end else if (lce > uce) begin
                        lc_reg      <= lce;
                        uc_reg      <= uce;
                        op_half_reg <= rmth_pkg::HALF_UPPER;
                        idx_reg     <= uce[AW-1:0];
                        need2_reg   <= 1'b0;
                    end else if (uce != '0 && samp_reg > up_top_reg) begin
                        // sample replaces upper min, old min moves down
                        lc_reg      <= lce;
                        uc_reg      <= ucm1;
                        op_half_reg <= rmth_pkg::HALF_UPPER;
                        idx_reg     <= ucm1[AW-1:0];
                        need2_reg   <= 1'b1;
                        val2_reg    <= up_top_reg;
                        half2_reg   <= rmth_pkg::HALF_LOWER;
                    end else begin
                        lc_reg      <= lce;
                        uc_reg      <= uce;
                        op_half_reg <= rmth_pkg::HALF_LOWER;
                        idx_reg     <= lce[AW-1:0];
                        need2_reg   <= 1'b0;
                    end
                end
            end else begin
                // first step of an insert settles the new extreme
                if (first_reg && wr_en) begin
                    if (op_half_reg == rmth_pkg::HALF_LOWER) begin
                        lo_top_reg <= wr_data;
                    end else begin
                        up_top_reg <= wr_data;
                    end
                end
                if (fin && need2_reg) begin
                    first_reg <= 1'b1;
                end else if (wr_en) begin
                    first_reg <= 1'b0;
                end
                if (fin) begin
                    if (op_half_reg == rmth_pkg::HALF_LOWER) lc_reg <= lc_reg + 1'b1;
                    else                                     uc_reg <= uc_reg + 1'b1;
                    if (need2_reg) begin
                        need2_reg   <= 1'b0;
                        op_half_reg <= half2_reg;
                        op_val_reg  <= val2_reg;
                        idx_reg     <= (half2_reg == rmth_pkg::HALF_UPPER) ?
                                       uc_reg[AW-1:0] : lc_reg[AW-1:0];
                    end
                end else if (cmd.ins_cmp && shift) begin
                    idx_reg <= idx_reg - 1'b1;
                end
            end
            if (cmd.publish) med_reg <= lo_top_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en && op_half_reg == rmth_pkg::HALF_LOWER) lo_mem[idx_reg] <= wr_data;
        lo_rd_reg <= lo_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (wr_en && op_half_reg == rmth_pkg::HALF_UPPER) up_mem[idx_reg] <= wr_data;
        up_rd_reg <= up_mem[rd_addr];
    end

    assign median  = med_reg;
    assign dropped = drop_reg;

    // halves stay balanced: lower holds as many or one more
    a_balance: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, uc_reg} <= {1'b0, lc_reg}) && ({1'b0, lc_reg} <= {1'b0, uc_reg} + 1'b1))
        else $error("halves out of balance");

    a_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        lc_reg <= CW'(HALF_DEPTH))
        else $error("lower count over depth");

endmodule

FILE: sv/running_median_two_halves.sv
// Running median top level: stream ports around sequencer and datapath.
// Sequence: decide, then the insert walks down the half, a read and a compare per entry
//   shifted, ending at a read when the walk reaches entry 0; a sample crossing halves
//   adds a second insert. A dropped request goes from decide straight to publish.
// Throughput: one item at a time; the next request can be taken in the cycle the
//   result shows, if m_tready is high.
// Reset: aresetn synchronous active low; both halves read as empty, no clearing pass.
module running_median_two_halves #(
    parameter int HALF_DEPTH  = rmth_pkg::HALF_DEPTH_DEF,
    parameter int SAMPLE_BITS = rmth_pkg::SAMPLE_BITS_DEF,
    // tdata rounded up to whole bytes
    localparam int TDW = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDW-1:0]        s_tdata,   // [SAMPLE_BITS-1:0] sample
    input  logic                  s_tuser,   // restart
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDW-1:0]        m_tdata,   // [SAMPLE_BITS-1:0] median
    output logic                  m_tuser    // dropped
);

    rmth_pkg::cmd_t    cmd;
    rmth_pkg::status_t st;
    logic signed [SAMPLE_BITS-1:0] median;

    // request handshake and step sequencing
    rmth_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .st       (st)
    );

    // sorted halves; median is the max of the lower half
    rmth_dp #(
        .HALF_DEPTH  (HALF_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .st      (st),
        .sample  (s_tdata[SAMPLE_BITS-1:0]),
        .restart (s_tuser),
        .median  (median),
        .dropped (m_tuser)
    );

    // zero-fill pad bits above the median
    assign m_tdata = TDW'(unsigned'(median));

endmodule
